@@ sv/irpd_pkg.sv @@
// Shared types and constants for the pulse-distance infrared frame sender.
// Used by the top level; no dependencies.
`default_nettype none

package irpd_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // Frame phases.
  localparam logic [3:0] PH_IDLE = 4'd0;
  localparam logic [3:0] PH_HDR1 = 4'd1;
  localparam logic [3:0] PH_SEG1 = 4'd2;
  localparam logic [3:0] PH_GAP1 = 4'd3;
  localparam logic [3:0] PH_SEG2 = 4'd4;
  localparam logic [3:0] PH_GAP2 = 4'd5;
  localparam logic [3:0] PH_HDR2 = 4'd6;
  localparam logic [3:0] PH_SEG3 = 4'd7;
  localparam logic [3:0] PH_GAP3 = 4'd8;
  localparam logic [3:0] PH_SEG4 = 4'd9;

  // Configuration register indexes.
  localparam logic [2:0] REG_HEADER_MARK  = 3'd0;
  localparam logic [2:0] REG_HEADER_SPACE = 3'd1;
  localparam logic [2:0] REG_BIT_MARK     = 3'd2;
  localparam logic [2:0] REG_ZERO_SPACE   = 3'd3;
  localparam logic [2:0] REG_ONE_SPACE    = 3'd4;
  localparam logic [2:0] REG_SHORT_GAP    = 3'd5;
  localparam logic [2:0] REG_LONG_GAP     = 3'd6;

  // Register reset values, in ticks.
  localparam logic [15:0] RST_HEADER_MARK  = 16'd9000;
  localparam logic [15:0] RST_HEADER_SPACE = 16'd4500;
  localparam logic [15:0] RST_BIT_MARK     = 16'd656;
  localparam logic [15:0] RST_ZERO_SPACE   = 16'd544;
  localparam logic [15:0] RST_ONE_SPACE    = 16'd1640;
  localparam logic [15:0] RST_SHORT_GAP    = 16'd20000;
  localparam logic [15:0] RST_LONG_GAP     = 16'd40000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bit_index;
    logic       bit_value;
  } in_item_t;

  typedef struct packed {
    logic carrier_on;
    logic busy_res;
    logic frame_done;
  } out_item_t;

endpackage

`default_nettype wire

@@ sv/irpd_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module irpd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 138
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read of the address being
  // written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ sv/ir_pulse_distance_frame_sender_core.sv @@
// Top level of the pulse-distance infrared frame sender.
// Depends on irpd_pkg and irpd_ram.
`default_nettype none

// The block takes one transaction per clock cycle while in_stall is low: a
// one-microsecond tick, a frame-bit write, or a start. Every accepted
// transaction yields exactly one result transaction, which is registered
// into the output buffer. The frame state is updated in a single pass of logic
// at the edge the transaction is accepted, so sustained throughput is one
// transaction per cycle; in_stall rises only when the two-entry output
// buffer is full because the consumer has stalled. Frame bits live in a RAM of
// 2*(FIRST_SEGMENT_BITS+SECOND_SEGMENT_BITS) one-bit entries that is not
// cleared at reset: every bit a frame uses must be written before start.
// Configuration writes take effect at the next interval that is loaded.
module ir_pulse_distance_frame_sender_core
  import irpd_pkg::*;
#(
  parameter int FIRST_SEGMENT_BITS  = 36,
  parameter int SECOND_SEGMENT_BITS = 33
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration write port.
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_item,
  // Output channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_item
);

  localparam int STORE_DEPTH = 2 * (FIRST_SEGMENT_BITS + SECOND_SEGMENT_BITS);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int PW = AW + 1;
  localparam logic [PW-1:0] SEG1_END = PW'(FIRST_SEGMENT_BITS);
  localparam logic [PW-1:0] SEG2_END = PW'(FIRST_SEGMENT_BITS + SECOND_SEGMENT_BITS);
  localparam logic [PW-1:0] SEG3_END = PW'(2 * FIRST_SEGMENT_BITS + SECOND_SEGMENT_BITS);
  localparam logic [PW-1:0] SEG4_END = PW'(STORE_DEPTH);
  localparam logic [8:0]    DEPTH_9  = 9'(STORE_DEPTH);

  // Configuration registers.
  logic [15:0] header_mark_us, header_space_us, bit_mark_us, zero_space_us;
  logic [15:0] one_space_us, short_gap_us, long_gap_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_mark_us  <= RST_HEADER_MARK;
      header_space_us <= RST_HEADER_SPACE;
      bit_mark_us     <= RST_BIT_MARK;
      zero_space_us   <= RST_ZERO_SPACE;
      one_space_us    <= RST_ONE_SPACE;
      short_gap_us    <= RST_SHORT_GAP;
      long_gap_us     <= RST_LONG_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEADER_MARK:  header_mark_us  <= cfg_data;
        REG_HEADER_SPACE: header_space_us <= cfg_data;
        REG_BIT_MARK:     bit_mark_us     <= cfg_data;
        REG_ZERO_SPACE:   zero_space_us   <= cfg_data;
        REG_ONE_SPACE:    one_space_us    <= cfg_data;
        REG_SHORT_GAP:    short_gap_us    <= cfg_data;
        REG_LONG_GAP:     long_gap_us     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame state.
  logic [3:0]    phase, phase_next;
  logic [AW-1:0] bit_position, bit_position_next;
  logic [15:0]   time_left, time_left_next;
  logic          in_mark, in_mark_next;

  // Output buffer control.
  logic [1:0] out_count;
  logic       accept;
  logic       pop;

  assign in_stall  = (out_count == 2'd2);
  assign accept    = in_valid && !in_stall;
  assign out_valid = (out_count != 2'd0);
  assign pop       = out_valid && !out_stall;

  // Frame-bit store; the read address follows the next bit position so the
  // bit is ready when the current mark ends.
  logic          ram_we;
  logic [AW-1:0] wr_addr;
  logic          rd_bit;
  logic          fwd_hit;
  logic          fwd_val;
  logic          cur_bit;

  assign ram_we  = accept && (in_item.kind == KIND_WRITE) &&
                   ({1'b0, in_item.bit_index} < DEPTH_9);
  assign wr_addr = in_item.bit_index[AW-1:0];

  irpd_ram #(
    .WIDTH (1),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (wr_addr),
    .wr_data (in_item.bit_value),
    .rd_addr (bit_position_next),
    .rd_data (rd_bit)
  );

  // Forward a write that lands on the address being read in the same cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= ram_we && (wr_addr == bit_position_next);
    end
    fwd_val <= in_item.bit_value;
  end

  assign cur_bit = fwd_hit ? fwd_val : rd_bit;

  // Next-state and result logic for one transaction.
  logic          active;
  logic [PW-1:0] pos_inc;
  logic [PW-1:0] seg_end;
  out_item_t     result;

  assign active  = phase inside {[PH_HDR1:PH_SEG4]};
  assign pos_inc = PW'(bit_position) + PW'(1);

  always_comb begin
    case (phase)
      PH_SEG1: seg_end = SEG1_END;
      PH_SEG2: seg_end = SEG2_END;
      PH_SEG3: seg_end = SEG3_END;
      default: seg_end = SEG4_END;
    endcase
  end

  always_comb begin
    phase_next        = phase;
    bit_position_next = bit_position;
    time_left_next    = time_left;
    in_mark_next      = in_mark;
    result            = '0;
    if (accept) begin
      if (in_item.kind == KIND_TICK) begin
        if (active) begin
          result.carrier_on = in_mark;
          result.busy_res   = 1'b1;
          if (time_left > 16'd1) begin
            time_left_next = time_left - 16'd1;
          end else begin
            // The current interval ends; load the next one.
            case (phase)
              PH_HDR1, PH_HDR2: begin
                if (in_mark) begin
                  in_mark_next   = 1'b0;
                  time_left_next = header_space_us;
                end else begin
                  phase_next     = phase + 4'd1;
                  in_mark_next   = 1'b1;
                  time_left_next = bit_mark_us;
                end
              end
              PH_SEG1, PH_SEG2, PH_SEG3, PH_SEG4: begin
                if (in_mark) begin
                  in_mark_next   = 1'b0;
                  time_left_next = cur_bit ? one_space_us : zero_space_us;
                end else if (pos_inc < seg_end) begin
                  bit_position_next = pos_inc[AW-1:0];
                  in_mark_next      = 1'b1;
                  time_left_next    = bit_mark_us;
                end else if (phase == PH_SEG4) begin
                  phase_next        = PH_IDLE;
                  in_mark_next      = 1'b0;
                  time_left_next    = '0;
                  bit_position_next = '0;
                  result.frame_done = 1'b1;
                end else begin
                  bit_position_next = pos_inc[AW-1:0];
                  in_mark_next      = 1'b0;
                  if (phase == PH_SEG2) begin
                    phase_next     = PH_GAP2;
                    time_left_next = long_gap_us;
                  end else begin
                    phase_next     = phase + 4'd1;
                    time_left_next = short_gap_us;
                  end
                end
              end
              PH_GAP1, PH_GAP3: begin
                phase_next     = phase + 4'd1;
                in_mark_next   = 1'b1;
                time_left_next = bit_mark_us;
              end
              PH_GAP2: begin
                phase_next     = PH_HDR2;
                in_mark_next   = 1'b1;
                time_left_next = header_mark_us;
              end
              default: begin
                phase_next   = PH_IDLE;
                in_mark_next = 1'b0;
              end
            endcase
          end
        end else begin
          phase_next   = PH_IDLE;
          in_mark_next = 1'b0;
        end
      end else begin
        // Start is ignored while a frame is in progress.
        if ((in_item.kind == KIND_START) && !active) begin
          bit_position_next = '0;
          phase_next        = PH_HDR1;
          in_mark_next      = 1'b1;
          time_left_next    = header_mark_us;
        end
        result.busy_res   = phase_next inside {[PH_HDR1:PH_SEG4]};
        result.carrier_on = result.busy_res && in_mark_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      bit_position <= '0;
      time_left    <= '0;
      in_mark      <= 1'b0;
    end else begin
      phase        <= phase_next;
      bit_position <= bit_position_next;
      time_left    <= time_left_next;
      in_mark      <= in_mark_next;
    end
  end

  // Two-entry output buffer: the head drives the port, the second entry
  // catches a result while the head is stalled.
  out_item_t buf1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else begin
      case ({accept, pop})
        2'b10:   out_count <= out_count + 2'd1;
        2'b01:   out_count <= out_count - 2'd1;
        default: out_count <= out_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (out_count == 2'd2) begin
        out_item <= buf1;
        if (accept) begin
          buf1 <= result;
        end
      end else if (accept) begin
        out_item <= result;
      end
    end else if (accept) begin
      if (out_count == 2'd0) begin
        out_item <= result;
      end else begin
        buf1 <= result;
      end
    end
  end

endmodule

`default_nettype wire
